// ----- design/hrlp_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request-line parser package
// Phase codes, result codes, character constants and the parser state type.
// ----------------------------------------------------------------------------
package hrlp_pkg;

  // Ring positions are 13 bits; the ring depth is 2**POS_W, so position
  // arithmetic wraps naturally.
  localparam int POS_W = 13;
  localparam int VER_W = 10;
  localparam int BUF_DEPTH = 2 ** POS_W;

  typedef logic [POS_W-1:0] pos_t;
  typedef logic [VER_W-1:0] ver_t;

  // Parse phases.
  localparam logic [3:0] PH_START   = 4'd0;
  localparam logic [3:0] PH_METHOD  = 4'd1;
  localparam logic [3:0] PH_SP_URI  = 4'd2;
  localparam logic [3:0] PH_URI     = 4'd3;
  localparam logic [3:0] PH_HTTP    = 4'd4;
  localparam logic [3:0] PH_H       = 4'd5;
  localparam logic [3:0] PH_HT      = 4'd6;
  localparam logic [3:0] PH_HTT     = 4'd7;
  localparam logic [3:0] PH_HTTP_SL = 4'd8;
  localparam logic [3:0] PH_MAJ1    = 4'd9;
  localparam logic [3:0] PH_MAJ     = 4'd10;
  localparam logic [3:0] PH_MIN1    = 4'd11;
  localparam logic [3:0] PH_MIN     = 4'd12;
  localparam logic [3:0] PH_SP_END  = 4'd13;
  localparam logic [3:0] PH_ALMOST  = 4'd14;

  // Status codes.
  localparam logic [1:0] ST_MORE  = 2'd0;
  localparam logic [1:0] ST_DONE  = 2'd1;
  localparam logic [1:0] ST_ERROR = 2'd2;

  // Error kinds.
  localparam logic [1:0] ERR_NONE    = 2'd0;
  localparam logic [1:0] ERR_METHOD  = 2'd1;
  localparam logic [1:0] ERR_SYNTAX  = 2'd2;
  localparam logic [1:0] ERR_VERSION = 2'd3;

  // Method codes.
  localparam logic [1:0] MTH_UNKNOWN = 2'd0;
  localparam logic [1:0] MTH_GET     = 2'd1;
  localparam logic [1:0] MTH_POST    = 2'd2;
  localparam logic [1:0] MTH_HEAD    = 2'd3;

  // Characters.
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_SP    = 8'h20;
  localparam logic [7:0] CH_DOT   = 8'h2E;
  localparam logic [7:0] CH_SLASH = 8'h2F;
  localparam logic [7:0] CH_0     = 8'h30;
  localparam logic [7:0] CH_1     = 8'h31;
  localparam logic [7:0] CH_9     = 8'h39;
  localparam logic [7:0] CH_A     = 8'h41;
  localparam logic [7:0] CH_H     = 8'h48;
  localparam logic [7:0] CH_P     = 8'h50;
  localparam logic [7:0] CH_T     = 8'h54;
  localparam logic [7:0] CH_Z     = 8'h5A;
  localparam logic [7:0] CH_US    = 8'h5F;

  localparam logic [31:0] NAME_GET  = 32'h0047_4554;
  localparam logic [31:0] NAME_POST = 32'h504F_5354;
  localparam logic [31:0] NAME_HEAD = 32'h4845_4144;

  localparam logic [VER_W-1:0] VER_MAX = VER_W'(999);

  typedef struct packed {
    logic [3:0]  phase;
    logic [31:0] mchars;
    logic [2:0]  mlen;
    ver_t        major;
    ver_t        minor;
    pos_t        start_pos;
    pos_t        mend_pos;
    pos_t        ustart_pos;
    pos_t        uend_pos;
    pos_t        end_pos;
    logic        end_seen;
    logic [1:0]  mval;
  } state_t;

  typedef struct packed {
    logic [1:0] status;
    logic [1:0] err;
  } res_t;

  function automatic logic is_method_char(input logic [7:0] c);
    return c inside {[CH_A:CH_Z], CH_US};
  endfunction

  function automatic logic is_digit(input logic [7:0] c);
    return c inside {[CH_0:CH_9]};
  endfunction

  // acc * 10 + digit, saturating at 999. acc never exceeds 999.
  function automatic ver_t accumulate(input ver_t acc, input logic [7:0] c);
    logic [13:0] v;
    v = {1'b0, acc, 3'b000} + {3'b000, acc, 1'b0} + 14'(c - CH_0);
    return (v > 14'(VER_MAX)) ? VER_MAX : v[VER_W-1:0];
  endfunction

endpackage

// ----- design/hrlp_step.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// HTTP request-line parser step
// Next-state and result logic for one request byte.
// ----------------------------------------------------------------------------
module hrlp_step (
  input  hrlp_pkg::state_t cur_i,
  input  logic [7:0]       data_i,
  input  hrlp_pkg::pos_t   pos_i,
  output hrlp_pkg::state_t nxt_o,
  output hrlp_pkg::res_t   res_o
);

  hrlp_pkg::state_t s;
  logic [1:0]       status;
  logic [1:0]       err;
  logic [1:0]       cls;

  always_comb begin
    if (cur_i.mlen == 3'd3 && cur_i.mchars == hrlp_pkg::NAME_GET) begin
      cls = hrlp_pkg::MTH_GET;
    end else if (cur_i.mlen == 3'd4 && cur_i.mchars == hrlp_pkg::NAME_POST) begin
      cls = hrlp_pkg::MTH_POST;
    end else if (cur_i.mlen == 3'd4 && cur_i.mchars == hrlp_pkg::NAME_HEAD) begin
      cls = hrlp_pkg::MTH_HEAD;
    end else begin
      cls = hrlp_pkg::MTH_UNKNOWN;
    end
  end

  always_comb begin
    s      = cur_i;
    status = hrlp_pkg::ST_MORE;
    err    = hrlp_pkg::ERR_NONE;
    case (cur_i.phase)
      hrlp_pkg::PH_START: begin
        if (data_i != hrlp_pkg::CH_CR && data_i != hrlp_pkg::CH_LF) begin
          s           = '0;
          s.start_pos = pos_i;
          if (!hrlp_pkg::is_method_char(data_i)) begin
            err = hrlp_pkg::ERR_METHOD;
          end else begin
            s.mchars = {24'd0, data_i};
            s.mlen   = 3'd1;
            s.phase  = hrlp_pkg::PH_METHOD;
          end
        end
      end
      hrlp_pkg::PH_METHOD: begin
        if (data_i == hrlp_pkg::CH_SP) begin
          s.mend_pos = pos_i;
          s.mval     = cls;
          s.phase    = hrlp_pkg::PH_SP_URI;
        end else if (!hrlp_pkg::is_method_char(data_i)) begin
          err = hrlp_pkg::ERR_METHOD;
        end else begin
          // Only the first four name bytes are kept; the count stops at 7.
          if (cur_i.mlen < 3'd4) begin
            s.mchars = {cur_i.mchars[23:0], data_i};
          end
          if (cur_i.mlen != 3'd7) begin
            s.mlen = cur_i.mlen + 3'd1;
          end
        end
      end
      hrlp_pkg::PH_SP_URI: begin
        if (data_i == hrlp_pkg::CH_SLASH) begin
          s.ustart_pos = pos_i + hrlp_pkg::POS_W'(1);
          s.phase      = hrlp_pkg::PH_URI;
        end else if (data_i != hrlp_pkg::CH_SP) begin
          err = hrlp_pkg::ERR_SYNTAX;
        end
      end
      hrlp_pkg::PH_URI: begin
        if (data_i == hrlp_pkg::CH_SP) begin
          s.uend_pos = pos_i;
          s.phase    = hrlp_pkg::PH_HTTP;
        end
      end
      hrlp_pkg::PH_HTTP: begin
        if (data_i == hrlp_pkg::CH_H) begin
          s.phase = hrlp_pkg::PH_H;
        end else if (data_i != hrlp_pkg::CH_SP) begin
          err = hrlp_pkg::ERR_SYNTAX;
        end
      end
      hrlp_pkg::PH_H: begin
        if (data_i == hrlp_pkg::CH_T) s.phase = hrlp_pkg::PH_HT;
        else err = hrlp_pkg::ERR_SYNTAX;
      end
      hrlp_pkg::PH_HT: begin
        if (data_i == hrlp_pkg::CH_T) s.phase = hrlp_pkg::PH_HTT;
        else err = hrlp_pkg::ERR_SYNTAX;
      end
      hrlp_pkg::PH_HTT: begin
        if (data_i == hrlp_pkg::CH_P) s.phase = hrlp_pkg::PH_HTTP_SL;
        else err = hrlp_pkg::ERR_SYNTAX;
      end
      hrlp_pkg::PH_HTTP_SL: begin
        if (data_i == hrlp_pkg::CH_SLASH) s.phase = hrlp_pkg::PH_MAJ1;
        else err = hrlp_pkg::ERR_SYNTAX;
      end
      hrlp_pkg::PH_MAJ1: begin
        if (data_i inside {[hrlp_pkg::CH_1:hrlp_pkg::CH_9]}) begin
          s.major = hrlp_pkg::VER_W'(data_i - hrlp_pkg::CH_0);
          s.phase = hrlp_pkg::PH_MAJ;
        end else begin
          err = hrlp_pkg::ERR_VERSION;
        end
      end
      hrlp_pkg::PH_MAJ: begin
        if (data_i == hrlp_pkg::CH_DOT) begin
          s.phase = hrlp_pkg::PH_MIN1;
        end else if (hrlp_pkg::is_digit(data_i)) begin
          s.major = hrlp_pkg::accumulate(cur_i.major, data_i);
        end else begin
          err = hrlp_pkg::ERR_VERSION;
        end
      end
      hrlp_pkg::PH_MIN1: begin
        if (hrlp_pkg::is_digit(data_i)) begin
          s.minor = hrlp_pkg::VER_W'(data_i - hrlp_pkg::CH_0);
          s.phase = hrlp_pkg::PH_MIN;
        end else begin
          err = hrlp_pkg::ERR_VERSION;
        end
      end
      hrlp_pkg::PH_MIN: begin
        if (data_i == hrlp_pkg::CH_CR) begin
          s.phase = hrlp_pkg::PH_ALMOST;
        end else if (data_i == hrlp_pkg::CH_LF) begin
          status = hrlp_pkg::ST_DONE;
        end else if (data_i == hrlp_pkg::CH_SP) begin
          s.phase = hrlp_pkg::PH_SP_END;
        end else if (hrlp_pkg::is_digit(data_i)) begin
          s.minor = hrlp_pkg::accumulate(cur_i.minor, data_i);
        end else begin
          err = hrlp_pkg::ERR_VERSION;
        end
      end
      hrlp_pkg::PH_SP_END: begin
        if (data_i == hrlp_pkg::CH_CR) begin
          s.phase = hrlp_pkg::PH_ALMOST;
        end else if (data_i == hrlp_pkg::CH_LF) begin
          status = hrlp_pkg::ST_DONE;
        end else if (data_i != hrlp_pkg::CH_SP) begin
          err = hrlp_pkg::ERR_SYNTAX;
        end
      end
      hrlp_pkg::PH_ALMOST: begin
        // The line ends at the CR, one ring slot before this byte.
        s.end_pos  = pos_i - hrlp_pkg::POS_W'(1);
        s.end_seen = 1'b1;
        if (data_i == hrlp_pkg::CH_LF) status = hrlp_pkg::ST_DONE;
        else err = hrlp_pkg::ERR_SYNTAX;
      end
      default: begin
        err = hrlp_pkg::ERR_SYNTAX;
      end
    endcase

    if (err != hrlp_pkg::ERR_NONE) begin
      status  = hrlp_pkg::ST_ERROR;
      s.phase = hrlp_pkg::PH_START;
    end else if (status == hrlp_pkg::ST_DONE) begin
      if (!s.end_seen) begin
        s.end_pos = pos_i;
      end
      s.phase = hrlp_pkg::PH_START;
    end
  end

  assign nxt_o        = s;
  assign res_o.status = status;
  assign res_o.err    = err;

endmodule

// ----- design/http_request_line_parser_core.sv -----
`timescale 1ns / 1ps
// A request goes from in_* through the input and result registers to out_*;
// one request per cycle while out_ready is high. The parser state register is
// updated in the same cycle that a byte moves from input to result register.
// Reset (rst_n low, synchronous): both stages empty, parser in its start
// phase with every per-request field cleared to zero.
// ----------------------------------------------------------------------------
// HTTP request-line parser core
// Parses the request line one byte per request and reports status, method,
// version numbers and ring positions after every byte.
// ----------------------------------------------------------------------------
module http_request_line_parser_core (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [7:0]           in_data_byte,
  input  logic [12:0]          in_buffer_index,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [1:0]           out_status,
  output logic [1:0]           out_error_kind,
  output logic [1:0]           out_method_code,
  output logic [9:0]           out_version_major,
  output logic [9:0]           out_version_minor,
  output logic [12:0]          out_line_start_pos,
  output logic [12:0]          out_method_end_pos,
  output logic [12:0]          out_uri_start_pos,
  output logic [12:0]          out_uri_end_pos,
  output logic [12:0]          out_line_end_pos
);

  // Input register: one byte waiting to be parsed.
  logic                 in_v_r;
  logic [7:0]           data_r;
  hrlp_pkg::pos_t       pos_r;

  // Parser state, carried from byte to byte.
  hrlp_pkg::state_t     state_r;
  hrlp_pkg::state_t     state_nxt;
  hrlp_pkg::res_t       res;

  // Result register.
  logic                 out_v_r;
  hrlp_pkg::res_t       ores_r;
  hrlp_pkg::state_t     ostate_r;

  logic                 adv;

  // The byte in the input register is parsed whenever the result register
  // is empty or is being emptied this cycle. The input register refills in
  // the same cycle; with out_ready high, a full pipe takes a request per cycle.
  assign adv      = in_v_r && (!out_v_r || out_ready);
  assign in_ready = !in_v_r || adv;

  hrlp_step u_step (
    .cur_i  (state_r),
    .data_i (data_r),
    .pos_i  (pos_r),
    .nxt_o  (state_nxt),
    .res_o  (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_v_r  <= 1'b0;
      out_v_r <= 1'b0;
      state_r <= '0;
    end else begin
      if (in_ready) begin
        in_v_r <= in_valid;
      end
      if (adv) begin
        state_r <= state_nxt;
        out_v_r <= 1'b1;
      end else if (out_ready) begin
        out_v_r <= 1'b0;
      end
    end
  end

  // Payload registers carry no reset.
  always_ff @(posedge clk) begin
    if (in_ready && in_valid) begin
      data_r <= in_data_byte;
      // The ring depth equals the 13-bit index range, so the index is the
      // position as it stands.
      pos_r  <= in_buffer_index;
    end
    if (adv) begin
      ores_r   <= res;
      ostate_r <= state_nxt;
    end
  end

  assign out_valid          = out_v_r;
  assign out_status         = ores_r.status;
  assign out_error_kind     = ores_r.err;
  assign out_method_code    = ostate_r.mval;
  assign out_version_major  = ostate_r.major;
  assign out_version_minor  = ostate_r.minor;
  assign out_line_start_pos = ostate_r.start_pos;
  assign out_method_end_pos = ostate_r.mend_pos;
  assign out_uri_start_pos  = ostate_r.ustart_pos;
  assign out_uri_end_pos    = ostate_r.uend_pos;
  assign out_line_end_pos   = ostate_r.end_pos;

  // An error kind is reported exactly when the status is error.
  a_err_status: assert property (@(posedge clk) disable iff (!rst_n)
    out_v_r |-> ((ores_r.status == hrlp_pkg::ST_ERROR) ==
                 (ores_r.err != hrlp_pkg::ERR_NONE)))
    else $error("error kind and status disagree");

  // A finished or failed line always returns the parser to its start phase.
  a_back_to_start: assert property (@(posedge clk) disable iff (!rst_n)
    (adv && res.status != hrlp_pkg::ST_MORE) |=> state_r.phase == hrlp_pkg::PH_START)
    else $error("parser did not return to start phase");

  // With the result register empty, the core never stalls the input.
  a_no_stall: assert property (@(posedge clk) disable iff (!rst_n)
    !out_v_r |-> in_ready)
    else $error("input stalled with empty result register");

  // The result register mirrors the state written in the same cycle.
  a_mirror: assert property (@(posedge clk) disable iff (!rst_n)
    adv |=> ostate_r == state_r)
    else $error("result fields differ from parser state");

endmodule
